// ----- rtl/pfa_pkg.sv -----
package pfa_pkg;

  localparam int WordBitsDef = 32;
  localparam int FieldBits   = 32;

  // operation codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_INV = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MOD0 = 3'd0;
  localparam logic [2:0] REG_MOD1 = 3'd1;
  localparam logic [2:0] REG_MOD2 = 3'd2;
  localparam logic [2:0] REG_NINV = 3'd3;
  localparam logic [2:0] REG_RSQ0 = 3'd4;
  localparam logic [2:0] REG_RSQ1 = 3'd5;
  localparam logic [2:0] REG_RSQ2 = 3'd6;

  typedef struct packed {
    logic [1:0]           operation;
    logic [FieldBits-1:0] a_word0;
    logic [FieldBits-1:0] a_word1;
    logic [FieldBits-1:0] a_word2;
    logic [FieldBits-1:0] b_word0;
    logic [FieldBits-1:0] b_word1;
    logic [FieldBits-1:0] b_word2;
  } pfa_in_t;

  typedef struct packed {
    logic [FieldBits-1:0] r_word0;
    logic [FieldBits-1:0] r_word1;
    logic [FieldBits-1:0] r_word2;
    logic                 zero_inverse;
  } pfa_out_t;

  // datapath commands from the controller
  localparam logic [3:0] CMD_NOP      = 4'd0;
  localparam logic [3:0] CMD_LOAD     = 4'd1;
  localparam logic [3:0] CMD_ADDSUB   = 4'd2;
  localparam logic [3:0] CMD_MM_START = 4'd3;
  localparam logic [3:0] CMD_MM_STEP  = 4'd4;
  localparam logic [3:0] CMD_MM_FIN   = 4'd5;
  localparam logic [3:0] CMD_INV_STEP = 4'd6;
  localparam logic [3:0] CMD_INV_FIX  = 4'd7;

  // multiplication operand selects
  localparam logic [1:0] MSEL_AB   = 2'd0;
  localparam logic [1:0] MSEL_XRSQ = 2'd1;
  localparam logic [1:0] MSEL_XPOW = 2'd2;

  typedef struct packed {
    logic [3:0] cmd;
    logic [1:0] msel;
    logic [4:0] mstep;
  } pfa_ctl_t;

  typedef struct packed {
    logic       is_zero_a;
    logic       inv_done;
    logic       k_lt_n;
    logic       k_gt_n;
    logic [1:0] operation;
  } pfa_sts_t;

endpackage

// ----- rtl/prime_field_alu_three_word.sv -----
// Multiply: one Montgomery product = clear, 24 word steps on one shared word
// multiplier, final subtract. Inverse of zero goes straight to the result; inverse
// runs up to 2n = 192 loop steps plus two products (a loop shorter than n takes a third).
// One item at a time: the next is taken in the cycle after its result strobe.
// Reset (rst_n low, synchronous) clears control and config registers; no receiver stall.
module prime_field_alu_three_word #(
  parameter int WORD_BITS = pfa_pkg::WordBitsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pfa_pkg::pfa_in_t    in_item,
  output logic                out_valid,
  output pfa_pkg::pfa_out_t   out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import pfa_pkg::*;

  localparam int W = WORD_BITS;

  logic [W-1:0] cfg_r [7];
  logic [2:0]   ridx;
  logic         wr;
  pfa_ctl_t     ctl;
  pfa_sts_t     sts;
  logic         done, zflag;
  logic [3*W-1:0] res;

  assign ridx = cfg_paddr[4:2];
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 7; i++) cfg_r[i] <= '0;
    end else if (wr && ridx <= REG_RSQ2) begin
      cfg_r[ridx] <= W'(cfg_pwdata);
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (ridx <= REG_RSQ2) cfg_prdata = 32'(cfg_r[ridx]);
  end

  pfa_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .done, .zflag, .sts, .ctl
  );

  pfa_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk, .rst_n, .in_item,
    .modp({cfg_r[REG_MOD2], cfg_r[REG_MOD1], cfg_r[REG_MOD0]}),
    .ninv(cfg_r[REG_NINV]),
    .rsq({cfg_r[REG_RSQ2], cfg_r[REG_RSQ1], cfg_r[REG_RSQ0]}),
    .ctl, .sts, .result(res)
  );

  // result strobe
  assign out_valid = done;
  always_comb begin
    out_item.r_word0 = zflag ? '0 : FieldBits'(res[0 +: W]);
    out_item.r_word1 = zflag ? '0 : FieldBits'(res[W +: W]);
    out_item.r_word2 = zflag ? '0 : FieldBits'(res[2*W +: W]);
    out_item.zero_inverse = zflag;
  end

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside transaction");
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("start not taken");

endmodule

// ----- rtl/pfa_datapath.sv -----
module pfa_datapath #(
  parameter int WORD_BITS = pfa_pkg::WordBitsDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  pfa_pkg::pfa_in_t                in_item,
  input  logic [3*WORD_BITS-1:0]          modp,
  input  logic [WORD_BITS-1:0]            ninv,
  input  logic [3*WORD_BITS-1:0]          rsq,
  input  pfa_pkg::pfa_ctl_t               ctl,
  output pfa_pkg::pfa_sts_t               sts,
  output logic [3*WORD_BITS-1:0]          result
);
  import pfa_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int N  = 3 * W;
  localparam int KW = $clog2(2 * N + 1);
  localparam int BW = $clog2(N);

  logic [N-1:0]   a_r, b_r, u_r, v_r, x1_r, x2_r, res_r;
  logic [N-1:0]   a_nxt, b_nxt, u_nxt, v_nxt, x1_nxt, x2_nxt, res_nxt;
  logic           c_r, c_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [1:0]     op_r, op_nxt;
  // Montgomery accumulator: 6 words plus reduction carry
  logic [W-1:0]   t_r [6];
  logic [W-1:0]   t_nxt [6];
  logic           gc_r, gc_nxt;
  logic [W-1:0]   m_r, m_nxt;
  logic [N-1:0]   ma, mb;

  // one word multiply-accumulate per cycle
  logic [W-1:0]   mac_x, mac_y, mac_t, mac_c, mac_hi;
  logic [2*W-1:0] mac_p;
  logic [W-1:0]   mac_hi_r, mac_hi_nxt;
  logic [W:0]     s1, s2;

  function automatic logic [W-1:0] wsel(input logic [N-1:0] v, input logic [1:0] i);
    wsel = v[i*W +: W];
  endfunction

  // operand mux for the multiplier
  logic [N-1:0] powv;
  logic [KW:0]  bitk;
  always_comb begin
    bitk = (KW+1)'(2 * N) - {1'b0, k_r};
    powv = '0;
    if (bitk[KW])
      powv[0] = 1'b1;
    else if (bitk >= (KW+1)'(N))
      powv[N-1] = 1'b1;
    else
      powv[bitk[BW-1:0]] = 1'b1;
    case (ctl.msel)
      MSEL_AB:   begin ma = a_r;   mb = b_r;  end
      MSEL_XRSQ: begin ma = x1_r;  mb = rsq;  end
      MSEL_XPOW: begin ma = res_r; mb = powv; end
      default:   begin ma = a_r;   mb = b_r;  end
    endcase
  end

  // schedule: steps 0..8 products (i,j), 9..23 reduction (per i: m, three macs, carry)
  logic [4:0] ph, q;
  logic [1:0] si, sj, ri, rj;
  logic [2:0] rq, pidx, rpos;
  logic       prod_ph;
  always_comb begin
    ph = ctl.mstep;
    prod_ph = (ph < 5'd9);
    q = ph - 5'd9;
    if (ph >= 5'd6) begin
      si = 2'd2; sj = 2'(ph - 5'd6);
    end else if (ph >= 5'd3) begin
      si = 2'd1; sj = 2'(ph - 5'd3);
    end else begin
      si = 2'd0; sj = ph[1:0];
    end
    if (q >= 5'd10) begin
      ri = 2'd2; rq = 3'(q - 5'd10);
    end else if (q >= 5'd5) begin
      ri = 2'd1; rq = 3'(q - 5'd5);
    end else begin
      ri = 2'd0; rq = q[2:0];
    end
    rj   = 2'(rq - 3'd1);
    pidx = {1'b0, si} + {1'b0, sj};
    rpos = {1'b0, ri} + rq - 3'd1;
  end

  // multiplier operands for the current step
  always_comb begin
    mac_x = '0; mac_y = '0; mac_t = '0; mac_c = '0;
    if (ctl.cmd == CMD_MM_STEP) begin
      if (prod_ph) begin
        mac_x = wsel(ma, si);
        mac_y = wsel(mb, sj);
        mac_t = t_r[pidx];
        mac_c = (sj == 2'd0) ? '0 : mac_hi_r;
      end else if (rq == 3'd0) begin
        mac_x = ninv;
        mac_y = t_r[{1'b0, ri}];
      end else if (rq <= 3'd3) begin
        mac_x = m_r;
        mac_y = wsel(modp, rj);
        mac_t = t_r[rpos];
        mac_c = mac_hi_r;
      end
    end
  end

  assign mac_p  = mac_x * mac_y;
  assign s1     = {1'b0, mac_p[W-1:0]} + {1'b0, mac_t};
  assign s2     = {1'b0, s1[W-1:0]} + {1'b0, mac_c};
  assign mac_hi = mac_p[2*W-1:W] + W'(s1[W]) + W'(s2[W]);

  logic [N:0]     addv, subv;
  logic           geq_mod;
  logic [N-1:0]   tr;
  logic [N:0]     vmu, umv, x1d, x12, x2d;
  logic [W-1:0]   cy;
  logic [W:0]     ps;

  always_comb begin
    a_nxt   = a_r;   b_nxt  = b_r;   u_nxt = u_r;   v_nxt = v_r;
    x1_nxt  = x1_r;  x2_nxt = x2_r;  res_nxt = res_r;
    c_nxt   = c_r;   k_nxt  = k_r;   op_nxt = op_r;
    gc_nxt  = gc_r;  m_nxt  = m_r;   mac_hi_nxt = mac_hi_r;
    for (int i = 0; i < 6; i++) t_nxt[i] = t_r[i];
    addv = '0; subv = '0; geq_mod = 1'b0; tr = '0;
    vmu = '0; umv = '0; x1d = '0; x12 = '0; x2d = '0;
    cy = '0; ps = '0;

    case (ctl.cmd)
      CMD_LOAD: begin
        op_nxt = in_item.operation;
        a_nxt  = {W'(in_item.a_word2), W'(in_item.a_word1), W'(in_item.a_word0)};
        b_nxt  = {W'(in_item.b_word2), W'(in_item.b_word1), W'(in_item.b_word0)};
        u_nxt  = {W'(in_item.a_word2), W'(in_item.a_word1), W'(in_item.a_word0)};
        v_nxt  = modp;
        x1_nxt = N'(1);
        x2_nxt = '0;
        c_nxt  = 1'b0;
        k_nxt  = '0;
      end
      CMD_ADDSUB: begin
        if (op_r == OP_ADD) begin
          addv = {1'b0, a_r} + {1'b0, b_r};
          if (addv[N] || addv[N-1:0] >= modp) res_nxt = addv[N-1:0] - modp;
          else res_nxt = addv[N-1:0];
        end else begin
          subv = {1'b0, a_r} - {1'b0, b_r};
          if (subv[N]) res_nxt = subv[N-1:0] + modp;
          else res_nxt = subv[N-1:0];
        end
      end
      CMD_MM_START: begin
        for (int i = 0; i < 6; i++) t_nxt[i] = '0;
        gc_nxt = 1'b0;
        mac_hi_nxt = '0;
      end
      CMD_MM_STEP: begin
        if (prod_ph) begin
          // product pass: t[i+j] += a[i]*b[j] + carry, carry out to t[i+3]
          t_nxt[pidx] = s2[W-1:0];
          mac_hi_nxt = mac_hi;
          if (sj == 2'd2) t_nxt[pidx + 3'd1] = mac_hi;
        end else if (rq == 3'd0) begin
          // reduction factor from the current low word
          m_nxt = mac_p[W-1:0];
          mac_hi_nxt = '0;
        end else if (rq <= 3'd3) begin
          t_nxt[rpos] = s2[W-1:0];
          mac_hi_nxt = mac_hi;
        end else begin
          // propagate carry through the upper words
          cy = mac_hi_r;
          for (int j = 3; j < 6; j++) begin
            if (j >= int'(ri) + 3) begin
              ps = {1'b0, t_r[j]} + {1'b0, cy};
              t_nxt[j] = ps[W-1:0];
              cy = W'(ps[W]);
            end
          end
          gc_nxt = gc_r | cy[0];
        end
      end
      CMD_MM_FIN: begin
        tr = {t_r[5], t_r[4], t_r[3]};
        geq_mod = tr >= modp;
        if (gc_r || geq_mod) res_nxt = tr - modp;
        else res_nxt = tr;
        // short loop: first R^2 product goes back to x1 and counts n more steps
        if (ctl.msel == MSEL_XRSQ && k_r < KW'(N)) begin
          x1_nxt = res_nxt;
          k_nxt  = k_r + KW'(N);
        end
      end
      CMD_INV_STEP: begin
        vmu = {1'b0, v_r} - {1'b0, u_r};
        umv = {1'b0, u_r} - {1'b0, v_r};
        x1d = {1'b0, x1_r} + {1'b0, x1_r};
        x2d = {1'b0, x2_r} + {1'b0, x2_r};
        x12 = {1'b0, x1_r} + {1'b0, x2_r};
        if (!v_r[0]) begin
          v_nxt = v_r >> 1;
          x1_nxt = x1d[N-1:0]; c_nxt = x1d[N];
        end else if (!u_r[0]) begin
          u_nxt = u_r >> 1;
          x2_nxt = x2d[N-1:0];
        end else if (v_r >= u_r) begin
          v_nxt = vmu[N-1:0] >> 1;
          x2_nxt = x12[N-1:0];
          x1_nxt = x1d[N-1:0]; c_nxt = x1d[N];
        end else begin
          u_nxt = umv[N-1:0] >> 1;
          x1_nxt = x12[N-1:0];
          x2_nxt = x2d[N-1:0];
        end
        k_nxt = k_r + KW'(1);
      end
      CMD_INV_FIX: begin
        if (c_r || x1_r >= modp) x1_nxt = x1_r - modp;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt; b_r <= b_nxt; u_r <= u_nxt; v_r <= v_nxt;
    x1_r <= x1_nxt; x2_r <= x2_nxt; res_r <= res_nxt;
    c_r <= c_nxt; m_r <= m_nxt; mac_hi_r <= mac_hi_nxt; gc_r <= gc_nxt;
    for (int i = 0; i < 6; i++) t_r[i] <= t_nxt[i];
    if (!rst_n) begin
      k_r <= '0; op_r <= OP_ADD;
    end else begin
      k_r <= k_nxt; op_r <= op_nxt;
    end
  end

  assign sts.is_zero_a = (a_r == '0);
  assign sts.inv_done  = (v_r == '0) || (k_r >= KW'(2 * N));
  assign sts.k_lt_n    = k_r < KW'(N);
  assign sts.k_gt_n    = k_r > KW'(N);
  assign sts.operation = op_r;
  assign result = res_r;

endmodule

// ----- rtl/pfa_ctrl.sv -----
module pfa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output logic               zflag,
  input  pfa_pkg::pfa_sts_t  sts,
  output pfa_pkg::pfa_ctl_t  ctl
);
  import pfa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DISP = 4'd1;
  localparam logic [3:0] S_AS   = 4'd2;
  localparam logic [3:0] S_MMI  = 4'd3;
  localparam logic [3:0] S_MM   = 4'd4;
  localparam logic [3:0] S_MMF  = 4'd5;
  localparam logic [3:0] S_INV  = 4'd6;
  localparam logic [3:0] S_FIX  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  // last schedule step: 9 products, 3 x 5 reduction steps
  localparam logic [4:0] LastStep = 5'd23;

  logic [3:0] st_r, st_nxt;
  logic [4:0] step_r, step_nxt;
  logic [1:0] mode_r, mode_nxt;   // which multiplication of the sequence
  logic       z_r, z_nxt;

  always_comb begin
    st_nxt = st_r; step_nxt = step_r; mode_nxt = mode_r; z_nxt = z_r;
    ctl.cmd = CMD_NOP; ctl.msel = mode_r; ctl.mstep = step_r;
    case (st_r)
      S_IDLE: if (start) begin
        ctl.cmd = CMD_LOAD; st_nxt = S_DISP; z_nxt = 1'b0;
      end
      S_DISP: begin
        case (sts.operation)
          OP_ADD, OP_SUB: st_nxt = S_AS;
          OP_MUL: begin mode_nxt = MSEL_AB; st_nxt = S_MMI; end
          default: begin
            if (sts.is_zero_a) begin z_nxt = 1'b1; st_nxt = S_DONE; end
            else st_nxt = S_INV;
          end
        endcase
      end
      S_AS: begin ctl.cmd = CMD_ADDSUB; st_nxt = S_DONE; end
      S_INV: begin
        if (sts.inv_done) st_nxt = S_FIX;
        else ctl.cmd = CMD_INV_STEP;
      end
      S_FIX: begin ctl.cmd = CMD_INV_FIX; mode_nxt = MSEL_XRSQ; st_nxt = S_MMI; end
      S_MMI: begin ctl.cmd = CMD_MM_START; step_nxt = '0; st_nxt = S_MM; end
      S_MM: begin
        ctl.cmd = CMD_MM_STEP;
        step_nxt = step_r + 5'd1;
        if (step_r == LastStep) st_nxt = S_MMF;
      end
      S_MMF: begin
        ctl.cmd = CMD_MM_FIN;
        st_nxt = S_DONE;
        if (mode_r == MSEL_XRSQ) begin
          // first R^2 product only when the loop ran short
          if (sts.k_lt_n) st_nxt = S_MMI;
          else if (sts.k_gt_n) begin mode_nxt = MSEL_XPOW; st_nxt = S_MMI; end
        end
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; step_r <= '0; mode_r <= MSEL_AB; z_r <= 1'b0;
    end else begin
      st_r <= st_nxt; step_r <= step_nxt; mode_r <= mode_nxt; z_r <= z_nxt;
    end
  end

  assign busy  = (st_r != S_IDLE);
  assign done  = (st_r == S_DONE);
  assign zflag = z_r;

endmodule
